// ===== rtl/smmu_pkg.sv =====
// Shared types, constants and helper functions of the segmented MMU translate and check block.
package smmu_pkg;

   localparam int unsigned TABLE_DEPTH = 64;
   localparam int unsigned IDX_W       = 6;
   localparam int unsigned WORD_W      = 16;
   localparam int unsigned PA_W        = 22;
   localparam int unsigned MEM_W       = 23;
   localparam int unsigned CSR_IDX_W   = 1;

   // Operation codes carried in the mode field of an input item.
   typedef enum logic [2:0] {
      MODE_TRANSLATE    = 3'd0,
      MODE_TABLE_READ   = 3'd1,
      MODE_TABLE_WORD   = 3'd2,
      MODE_TABLE_BYTE   = 3'd3,
      MODE_STATUS_WRITE = 3'd4
   } op_mode_type;

   typedef enum logic [1:0] {
      FAULT_NONE  = 2'd0,
      FAULT_ABORT = 2'd1,
      FAULT_TRAP  = 2'd2
   } fault_type;

   // Access control codes held in descriptor bits 2..0.
   localparam logic [2:0] AC_NON_RESIDENT = 3'd0;
   localparam logic [2:0] AC_RD_TRAP      = 3'd1;
   localparam logic [2:0] AC_RD_ONLY      = 3'd2;
   localparam logic [2:0] AC_RW_TRAP_ALL  = 3'd4;
   localparam logic [2:0] AC_RW_TRAP_WR   = 3'd5;
   localparam logic [2:0] AC_RW           = 3'd6;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MMR3    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEMSIZE = 1'b1;

   localparam logic [15:0]      MMR3_RESET    = 16'h0000;
   localparam logic [MEM_W-1:0] MEMSIZE_RESET = 23'd262144;
   localparam logic [PA_W-1:0]  IO_BASE18     = 22'o0760000;
   localparam logic [PA_W-1:0]  IO_BASE22     = 22'o17760000;
   localparam logic [15:0]      DESC_WR_CLEAR = 16'h80f0;
   localparam logic [15:0]      DESC_AW_CLEAR = 16'h00c0;
   localparam logic [15:0]      DESC_W_BIT    = 16'h0080;

   function automatic fault_type access_result(input logic [2:0] ac, input logic wr);
      fault_type res;
      case (ac)
         AC_RD_TRAP:     res = wr ? FAULT_ABORT : FAULT_TRAP;
         AC_RD_ONLY:     res = wr ? FAULT_ABORT : FAULT_NONE;
         AC_RW_TRAP_ALL: res = FAULT_TRAP;
         AC_RW_TRAP_WR:  res = wr ? FAULT_TRAP : FAULT_NONE;
         AC_RW:          res = FAULT_NONE;
         default:        res = FAULT_ABORT;
      endcase
      return res;
   endfunction

   function automatic logic [15:0] byte_merge(input logic [15:0] w, input logic high,
                                              input logic [7:0] v);
      logic [15:0] res;
      res = high ? {v, w[7:0]} : {w[15:8], v};
      return res;
   endfunction

endpackage

// ===== rtl/smmu_ifaces.sv =====
// Request and response channel interfaces of the segmented MMU translate and check block.
interface smmu_req_if;
   import smmu_pkg::*;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [1:0]  cpu_mode;
   logic [15:0] vaddr;
   logic        write_access;
   logic        data_space;
   logic        check_access;
   logic        table_select;
   logic [WORD_W-1:0] write_data;

   modport source (output valid, mode, cpu_mode, vaddr, write_access, data_space,
                   check_access, table_select, write_data, input ready);
   modport sink   (input valid, mode, cpu_mode, vaddr, write_access, data_space,
                   check_access, table_select, write_data, output ready);
endinterface

interface smmu_rsp_if;
   import smmu_pkg::*;
   logic              valid;
   logic              ready;
   logic [PA_W-1:0]   physical_address;
   logic [1:0]        fault;
   logic [WORD_W-1:0] read_data;
   logic [WORD_W-1:0] status_value;

   modport source (output valid, physical_address, fault, read_data, status_value,
                   input ready);
   modport sink   (input valid, physical_address, fault, read_data, status_value,
                   output ready);
endinterface

// ===== rtl/smmu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module smmu_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 64,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/segmented_mmu_translate_check.sv =====
// Top level of the segmented MMU: translation, access checks and table/status maintenance.
// The table read happens at the accepting edge, as stage one captures the item; the result
// register loads when stage one advances, which waits while the held result is not taken.
// Throughput: one item per cycle without stalls; the table read and one-pass check set it.
// Reset (synchronous, active high) clears status and the per-entry valid bits and returns the
// configuration to its defaults; an entry never written reads as zero, so no clearing pass.
module segmented_mmu_translate_check (
   input  logic                            clock,
   input  logic                            reset,
   smmu_req_if.sink                        req_ch,
   smmu_rsp_if.source                      rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [smmu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [smmu_pkg::MEM_W-1:0]      csr_wr_data
);
   import smmu_pkg::*;

   // Configuration registers.
   logic [15:0]      mmr3_ff, mmr3_in;
   logic [MEM_W-1:0] memsize_ff, memsize_in;

   // Status register (the fault and enable register of the MMU).
   logic [15:0] status_ff, status_in;

   // Stage one: captured item, waiting for the table read data.
   logic              s1_valid_ff, s1_valid_in;
   logic [2:0]        s1_mode_ff;
   logic [1:0]        s1_rm_ff;
   logic [15:0]       s1_va_ff;
   logic              s1_wr_ff;
   logic              s1_chk_ff;
   logic              s1_sel_ff;
   logic              s1_d_ff;
   logic [WORD_W-1:0] s1_wd_ff;
   logic [IDX_W-1:0]  s1_idx_ff;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PA_W-1:0]   rsp_pa_ff;
   logic [1:0]        rsp_fault_ff;
   logic [WORD_W-1:0] rsp_rd_ff;
   logic [WORD_W-1:0] rsp_status_ff;

   // Entry valid bits and the last write of each table, for read-after-write forwarding.
   logic [TABLE_DEPTH-1:0] desc_valid_ff, desc_valid_in;
   logic [TABLE_DEPTH-1:0] base_valid_ff, base_valid_in;
   logic                   desc_last_en_ff, base_last_en_ff;
   logic [IDX_W-1:0]       desc_last_addr_ff, base_last_addr_ff;
   logic [WORD_W-1:0]      desc_last_data_ff, base_last_data_ff;

   logic              req_fire;
   logic              advance;
   logic              req_d;
   logic [IDX_W-1:0]  req_idx;
   logic              data_en;

   logic [WORD_W-1:0] desc_q, base_q;
   logic [WORD_W-1:0] pdr_cur, base_cur;

   logic              desc_we, base_we;
   logic [WORD_W-1:0] desc_wdata, base_wdata;

   logic [PA_W-1:0]   pa_next;
   logic [1:0]        fault_next;
   logic [WORD_W-1:0] rd_next;

   // Translation datapath signals.
   logic              big_mode;
   logic              map_on;
   logic              locked;
   logic [2:0]        apf;
   logic [2:0]        ac;
   logic [MEM_W-1:0]  xlat_sum;
   logic [PA_W-1:0]   xlat_addr;
   logic [PA_W-1:0]   io_base;
   logic              nxm;
   logic              len_fail;
   fault_type         acc;
   logic              acc_nonres;
   logic              acc_ro;
   logic [15:0]       acc_status, nxm_status, len_status;

   // The handshake: stage one drains into the result register whenever that register is
   // empty or its item is being taken, so an item can enter every cycle.
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // Data space is used for translation only when the run mode has it enabled in MMR3.
   // Supervisor and kernel map onto bits 1 and 2; the unused run mode never has it.
   always_comb begin
      case (req_ch.cpu_mode)
         2'd0:    data_en = mmr3_ff[2];
         2'd1:    data_en = mmr3_ff[1];
         2'd3:    data_en = mmr3_ff[0];
         default: data_en = 1'b0;
      endcase
   end

   // Table index is {run mode, space, page}. Translation takes the page from the top three
   // address bits; table accesses take space and page from the low address bits.
   always_comb begin
      if (op_mode_type'(req_ch.mode) == MODE_TRANSLATE) begin
         req_d   = req_ch.data_space && data_en;
         req_idx = {req_ch.cpu_mode, req_d, req_ch.vaddr[15:13]};
      end else begin
         req_d   = req_ch.vaddr[4];
         req_idx = {req_ch.cpu_mode, req_ch.vaddr[4], req_ch.vaddr[3:1]};
      end
   end

   smmu_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_desc_ram (
      .clock   (clock),
      .wr_en   (advance && desc_we),
      .wr_addr (s1_idx_ff),
      .wr_data (desc_wdata),
      .rd_en   (req_fire),
      .rd_addr (req_idx),
      .rd_data (desc_q)
   );

   smmu_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_base_ram (
      .clock   (clock),
      .wr_en   (advance && base_we),
      .wr_addr (s1_idx_ff),
      .wr_data (base_wdata),
      .rd_en   (req_fire),
      .rd_addr (req_idx),
      .rd_data (base_q)
   );

   // The RAM read may come in the same cycle as the previous item's write, and then misses
   // that write; the last-write registers supply it. Unwritten entries read as zero.
   always_comb begin
      if (desc_last_en_ff && (desc_last_addr_ff == s1_idx_ff)) begin
         pdr_cur = desc_last_data_ff;
      end else if (desc_valid_ff[s1_idx_ff]) begin
         pdr_cur = desc_q;
      end else begin
         pdr_cur = '0;
      end
      if (base_last_en_ff && (base_last_addr_ff == s1_idx_ff)) begin
         base_cur = base_last_data_ff;
      end else if (base_valid_ff[s1_idx_ff]) begin
         base_cur = base_q;
      end else begin
         base_cur = '0;
      end
   end

   // Address relocation and the three checks, all from the captured item and table words.
   assign big_mode  = mmr3_ff[4];
   assign map_on    = status_ff[0] || (s1_wr_ff && status_ff[8]);
   assign locked    = status_ff[15:13] != 3'b000;
   assign apf       = s1_va_ff[15:13];
   assign ac        = pdr_cur[2:0];
   assign xlat_sum  = {1'b0, base_cur, 6'b000000} + {10'd0, s1_va_ff[12:0]};
   assign xlat_addr = big_mode ? xlat_sum[PA_W-1:0] : {4'b0000, xlat_sum[17:0]};
   assign io_base   = big_mode ? IO_BASE22 : IO_BASE18;
   assign nxm       = ({1'b0, xlat_addr} >= memsize_ff) && (xlat_addr < io_base);
   // Expand-up pages fault past the length field, expand-down pages below it.
   assign len_fail  = pdr_cur[3] ? (s1_va_ff[12:6] < pdr_cur[14:8])
                                 : (s1_va_ff[12:6] > pdr_cur[14:8]);
   assign acc       = access_result(ac, s1_wr_ff);

   // Status words for each kind of fault. Non-resident and trap-all codes report as
   // non-resident; everything else, and any write not to a full-access page, as read-only.
   assign acc_nonres = (ac == AC_NON_RESIDENT) || (ac == AC_RW_TRAP_ALL);
   assign acc_ro     = (s1_wr_ff && (ac != AC_RW)) || !acc_nonres;
   assign acc_status = {acc_nonres, 1'b0, acc_ro, 1'b0, status_ff[11:7], s1_rm_ff, s1_d_ff,
                        apf, status_ff[0]};
   assign nxm_status = {3'b100, status_ff[12:7], s1_rm_ff, status_ff[4], apf, status_ff[0]};
   assign len_status = {3'b010, status_ff[12:7], s1_rm_ff, s1_d_ff, apf, status_ff[0]};

   always_comb begin
      fault_type   flt;
      logic [15:0] new_word;
      logic [15:0] sv;
      flt        = FAULT_NONE;
      new_word   = '0;
      sv         = '0;
      pa_next    = '0;
      rd_next    = '0;
      status_in  = status_ff;
      desc_we    = 1'b0;
      base_we    = 1'b0;
      desc_wdata = pdr_cur;
      base_wdata = base_cur;
      case (op_mode_type'(s1_mode_ff))
         MODE_TRANSLATE: begin
            pa_next = {6'd0, s1_va_ff};
            if (map_on) begin
               // A faulting translation still reports the relocated address.
               pa_next = xlat_addr;
               if (s1_chk_ff) begin
                  if (acc != FAULT_NONE) begin
                     flt = acc;
                     if (!locked) begin
                        status_in = acc_status;
                     end
                  end else if (nxm) begin
                     flt = FAULT_ABORT;
                     if (!locked) begin
                        status_in = nxm_status;
                     end
                  end else if (len_fail) begin
                     flt = FAULT_TRAP;
                     if (!locked) begin
                        status_in = len_status;
                     end
                  end
                  // A faulting write marks the page's descriptor.
                  if ((flt != FAULT_NONE) && s1_wr_ff) begin
                     desc_we    = 1'b1;
                     desc_wdata = pdr_cur | DESC_W_BIT;
                  end
               end
            end
         end
         MODE_TABLE_READ: begin
            rd_next = s1_sel_ff ? base_cur : pdr_cur;
         end
         MODE_TABLE_WORD, MODE_TABLE_BYTE: begin
            if (s1_sel_ff) begin
               new_word = (op_mode_type'(s1_mode_ff) == MODE_TABLE_BYTE)
                          ? byte_merge(base_cur, s1_va_ff[0], s1_wd_ff[7:0]) : s1_wd_ff;
               base_we    = 1'b1;
               base_wdata = new_word;
               desc_we    = 1'b1;
               desc_wdata = pdr_cur & ~DESC_AW_CLEAR;
            end else begin
               new_word = (op_mode_type'(s1_mode_ff) == MODE_TABLE_BYTE)
                          ? byte_merge(pdr_cur, s1_va_ff[0], s1_wd_ff[7:0]) : s1_wd_ff;
               desc_we    = 1'b1;
               desc_wdata = new_word & ~DESC_WR_CLEAR;
            end
         end
         MODE_STATUS_WRITE: begin
            // Bits 11 and 10 are read-only zero. Enabling mapping clears the error flags;
            // while locked, a write that leaves mapping off keeps only bits 7 to 1.
            sv = s1_wd_ff & 16'hf3ff;
            if (sv[0]) begin
               sv = sv & 16'h1fff;
            end
            if (locked && !sv[0]) begin
               sv = sv & 16'h00fe;
            end
            status_in = sv;
         end
         default: begin
         end
      endcase
      fault_next = 2'(flt);
   end

   always_comb begin
      mmr3_in    = mmr3_ff;
      memsize_in = memsize_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MMR3:    mmr3_in    = csr_wr_data[15:0];
            CSR_MEMSIZE: memsize_in = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      desc_valid_in = desc_valid_ff;
      base_valid_in = base_valid_ff;
      if (advance) begin
         s1_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
         if (desc_we) begin
            desc_valid_in[s1_idx_ff] = 1'b1;
         end
         if (base_we) begin
            base_valid_in[s1_idx_ff] = 1'b1;
         end
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mmr3_ff         <= MMR3_RESET;
         memsize_ff      <= MEMSIZE_RESET;
         status_ff       <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         desc_valid_ff   <= '0;
         base_valid_ff   <= '0;
         desc_last_en_ff <= 1'b0;
         base_last_en_ff <= 1'b0;
      end else begin
         mmr3_ff       <= mmr3_in;
         memsize_ff    <= memsize_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         desc_valid_ff <= desc_valid_in;
         base_valid_ff <= base_valid_in;
         if (advance) begin
            status_ff <= status_in;
            if (desc_we) begin
               desc_last_en_ff <= 1'b1;
            end
            if (base_we) begin
               base_last_en_ff <= 1'b1;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff <= req_ch.mode;
         s1_rm_ff   <= req_ch.cpu_mode;
         s1_va_ff   <= req_ch.vaddr;
         s1_wr_ff   <= req_ch.write_access;
         s1_chk_ff  <= req_ch.check_access;
         s1_sel_ff  <= req_ch.table_select;
         s1_d_ff    <= req_d;
         s1_wd_ff   <= req_ch.write_data;
         s1_idx_ff  <= req_idx;
      end
      if (advance) begin
         rsp_pa_ff     <= pa_next;
         rsp_fault_ff  <= fault_next;
         rsp_rd_ff     <= rd_next;
         rsp_status_ff <= status_in;
         if (desc_we) begin
            desc_last_addr_ff <= s1_idx_ff;
            desc_last_data_ff <= desc_wdata;
         end
         if (base_we) begin
            base_last_addr_ff <= s1_idx_ff;
            base_last_data_ff <= base_wdata;
         end
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.physical_address = rsp_pa_ff;
   assign rsp_ch.fault            = rsp_fault_ff;
   assign rsp_ch.read_data        = rsp_rd_ff;
   assign rsp_ch.status_value     = rsp_status_ff;

endmodule

// ===== tb/sv/segmented_mmu_translate_check_test.sv =====
// Self-checking testbench for the segmented MMU translate and check block.
module segmented_mmu_translate_check_test;
   import smmu_pkg::*;

   // One input item as the testbench sees it, and one expected result.
   typedef struct {
      op_mode_type mode;
      logic [1:0]  cpu_mode;
      logic [15:0] vaddr;
      logic        write_access;
      logic        data_space;
      logic        check_access;
      logic        table_select;
      logic [15:0] wdata;
   } mmu_req_type;

   typedef struct {
      logic [PA_W-1:0]   paddr;
      logic [1:0]        fault;
      logic [WORD_W-1:0] rdata;
      logic [WORD_W-1:0] status;
   } mmu_rsp_type;

   // Backstop for a hung handshake; far beyond the slowest legal run.
   localparam longint TIMEOUT_UNITS = 64'd40_000_000;
   localparam int     ITEMS_PER_SETTING = 330;

   logic clock = 1'b0;
   logic reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [MEM_W-1:0]     csr_wr_data;

   smmu_req_if req_bus ();
   smmu_rsp_if rsp_bus ();

   segmented_mmu_translate_check dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the block's state and configuration, kept in step with
   // every accepted item and every register write.
   logic [15:0]      pbr_shadow [TABLE_DEPTH];
   logic [15:0]      pdr_shadow [TABLE_DEPTH];
   logic [15:0]      sr0_shadow;
   logic [15:0]      mmr3_shadow;
   logic [MEM_W-1:0] memsize_shadow;

   // Results still owed by the block, oldest first.
   mmu_rsp_type pending_rsp [$];

   int  error_count     = 0;
   int  items_sent      = 0;
   int  results_checked = 0;
   int  settings_count  = 0;
   int  abort_count     = 0;
   int  trap_count      = 0;
   bit  idle_on         = 1'b1;
   int  stall_left      = 0;

   always #10 clock = ~clock;

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Predict the result of one item and advance the shadow state.
   function automatic mmu_rsp_type mmu_step(input mmu_req_type it);
      mmu_rsp_type     r;
      logic            lk, d, denable, big, down;
      logic [2:0]      apf, ac;
      logic [5:0]      idx;
      logic [15:0]     pdr, t, v;
      logic [22:0]     sum;
      logic [PA_W-1:0] io_base;
      logic [6:0]      len, blk;
      fault_type       act;

      r.paddr = '0;
      r.fault = FAULT_NONE;
      r.rdata = '0;
      // The lock is judged on the status register as it stood before this item.
      lk = (sr0_shadow[15:13] != 3'b000);

      case (it.mode)
         MODE_TRANSLATE: begin
            r.paddr = {6'd0, it.vaddr};
            // Mapping is on with status bit 0, or for writes in maintenance mode.
            if (sr0_shadow[0] || (it.write_access && sr0_shadow[8])) begin
               apf = it.vaddr[15:13];
               case (it.cpu_mode)
                  2'd0:    denable = mmr3_shadow[2];
                  2'd1:    denable = mmr3_shadow[1];
                  2'd3:    denable = mmr3_shadow[0];
                  default: denable = 1'b0;
               endcase
               d   = it.data_space && denable;
               idx = {it.cpu_mode, d, apf};
               pdr = pdr_shadow[idx];
               big = mmr3_shadow[4];
               sum = {1'b0, pbr_shadow[idx], 6'd0} + {10'd0, it.vaddr[12:0]};
               r.paddr = big ? sum[21:0] : {4'd0, sum[17:0]};
               if (it.check_access) begin
                  ac = pdr[2:0];
                  case (ac)
                     AC_RW:          act = FAULT_NONE;
                     AC_RD_ONLY:     act = it.write_access ? FAULT_ABORT : FAULT_NONE;
                     AC_RW_TRAP_WR:  act = it.write_access ? FAULT_TRAP : FAULT_NONE;
                     AC_RD_TRAP:     act = it.write_access ? FAULT_ABORT : FAULT_TRAP;
                     AC_RW_TRAP_ALL: act = FAULT_TRAP;
                     default:        act = FAULT_ABORT;
                  endcase
                  io_base = big ? IO_BASE22 : IO_BASE18;
                  len  = pdr[14:8];
                  blk  = it.vaddr[12:6];
                  down = pdr[3];
                  if (act != FAULT_NONE) begin
                     if (!lk) begin
                        t = sr0_shadow & 16'h0f81;
                        if (it.write_access && ac != AC_RW) t[13] = 1'b1;
                        if (ac == AC_NON_RESIDENT || ac == AC_RW_TRAP_ALL) t[15] = 1'b1;
                        else t[13] = 1'b1;
                        t[6:5] = it.cpu_mode;
                        t[4]   = d;
                        t[3:1] = apf;
                        sr0_shadow = t;
                     end
                     r.fault = act;
                  end else if ({1'b0, r.paddr} >= memsize_shadow && r.paddr < io_base) begin
                     // Nonexistent memory: below the I/O page but above installed size.
                     if (!lk) begin
                        t = sr0_shadow & 16'o017777;
                        t[15]  = 1'b1;
                        t[6:5] = it.cpu_mode;
                        t[3:1] = apf;
                        sr0_shadow = t;
                     end
                     r.fault = FAULT_ABORT;
                  end else if (down ? (blk < len) : (blk > len)) begin
                     if (!lk) begin
                        t = sr0_shadow & 16'o017777;
                        t[14]  = 1'b1;
                        t[6:5] = it.cpu_mode;
                        t[4]   = d;
                        t[3:1] = apf;
                        sr0_shadow = t;
                     end
                     r.fault = FAULT_TRAP;
                  end
                  // A faulting write marks the page as written.
                  if (r.fault != FAULT_NONE && it.write_access) pdr_shadow[idx][7] = 1'b1;
               end
            end
         end
         MODE_TABLE_READ, MODE_TABLE_WORD, MODE_TABLE_BYTE: begin
            idx = {it.cpu_mode, it.vaddr[4], it.vaddr[3:1]};
            if (it.mode == MODE_TABLE_READ) begin
               r.rdata = it.table_select ? pbr_shadow[idx] : pdr_shadow[idx];
            end else if (it.table_select) begin
               if (it.mode == MODE_TABLE_WORD) pbr_shadow[idx] = it.wdata;
               else if (it.vaddr[0]) pbr_shadow[idx][15:8] = it.wdata[7:0];
               else pbr_shadow[idx][7:0] = it.wdata[7:0];
               pdr_shadow[idx] = pdr_shadow[idx] & ~DESC_AW_CLEAR;
            end else begin
               if (it.mode == MODE_TABLE_WORD) pdr_shadow[idx] = it.wdata;
               else if (it.vaddr[0]) pdr_shadow[idx][15:8] = it.wdata[7:0];
               else pdr_shadow[idx][7:0] = it.wdata[7:0];
               pdr_shadow[idx] = pdr_shadow[idx] & ~DESC_WR_CLEAR;
            end
         end
         MODE_STATUS_WRITE: begin
            v = it.wdata & ~16'h0c00;
            if (v[0]) v[15:13] = 3'b000;
            if (lk && !v[0]) v = v & 16'h00fe;
            sr0_shadow = v;
         end
         default: begin
         end
      endcase
      r.status = sr0_shadow;
      return r;
   endfunction

   function automatic mmu_req_type make_item(input op_mode_type op, input logic [1:0] rm,
                                             input logic [15:0] va, input logic wr,
                                             input logic ds, input logic chk,
                                             input logic sel, input logic [15:0] wd);
      mmu_req_type it;
      it.mode         = op;
      it.cpu_mode     = rm;
      it.vaddr        = va;
      it.write_access = wr;
      it.data_space   = ds;
      it.check_access = chk;
      it.table_select = sel;
      it.wdata        = wd;
      return it;
   endfunction

   // Random traffic keeps mapping switched on most of the time and biases the
   // table writes toward usable pages, so translations reach every check.
   function automatic mmu_req_type random_item();
      mmu_req_type it;
      int          pick;
      pick = $urandom_range(0, 99);
      it.cpu_mode     = 2'($urandom_range(0, 3));
      it.vaddr        = 16'($urandom);
      it.write_access = 1'($urandom_range(0, 1));
      it.data_space   = 1'($urandom_range(0, 1));
      it.check_access = ($urandom_range(0, 9) != 0);
      it.table_select = 1'($urandom_range(0, 1));
      it.wdata        = 16'($urandom);
      if (pick < 55) begin
         it.mode = MODE_TRANSLATE;
      end else if (pick < 68) begin
         it.mode = MODE_TABLE_READ;
      end else if (pick < 92) begin
         it.mode = (pick < 80) ? MODE_TABLE_WORD : MODE_TABLE_BYTE;
         if (!it.table_select && $urandom_range(0, 1) == 1) it.wdata[2:0] = AC_RW;
         if (it.table_select && $urandom_range(0, 1) == 1)
            it.wdata = 16'($urandom_range(0, 16'h0fff));
      end else begin
         it.mode = MODE_STATUS_WRITE;
         if ($urandom_range(0, 3) != 0) it.wdata[0] = 1'b1;
      end
      return it;
   endfunction

   // Offer one item after an optional gap and hold it until the block takes it.
   // Valid stays high into the next item when there is no gap.
   task automatic send_item(input mmu_req_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.mode         <= it.mode;
      req_bus.cpu_mode     <= it.cpu_mode;
      req_bus.vaddr        <= it.vaddr;
      req_bus.write_access <= it.write_access;
      req_bus.data_space   <= it.data_space;
      req_bus.check_access <= it.check_access;
      req_bus.table_select <= it.table_select;
      req_bus.write_data   <= it.wdata;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_rsp.push_back(mmu_step(it));
      items_sent++;
   endtask

   // Stop offering items, let every owed result come back, then let the
   // pipeline settle so the block is truly idle.
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [MEM_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      if (idx == CSR_MMR3) mmr3_shadow = data[15:0];
      else memsize_shadow = data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic apply_settings(input logic [15:0] m3, input logic [MEM_W-1:0] msz);
      wait_idle();
      csr_write(CSR_MMR3, {7'd0, m3});
      csr_write(CSR_MEMSIZE, msz);
      settings_count++;
   endtask

   // Straight after reset mapping is off: addresses pass through unchecked.
   task automatic test_unmapped();
      send_item(make_item(MODE_TRANSLATE, 2'd3, 16'hffff, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0000));
      send_item(make_item(MODE_TABLE_READ, 2'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 16'hffff));
   endtask

   // Word and byte writes of both tables, then whole-word read-back whatever
   // the byte select bit says. User data page 7 sits at table offset 0x1e.
   task automatic test_table_access();
      send_item(make_item(MODE_TABLE_WORD, 2'd3, 16'h001f, 1'b0, 1'b0, 1'b0, 1'b1, 16'hffff));
      send_item(make_item(MODE_TABLE_WORD, 2'd3, 16'h001f, 1'b0, 1'b0, 1'b0, 1'b0, 16'hffff));
      send_item(make_item(MODE_TABLE_BYTE, 2'd3, 16'h001f, 1'b0, 1'b0, 1'b0, 1'b1, 16'hff00));
      send_item(make_item(MODE_TABLE_BYTE, 2'd3, 16'h001e, 1'b0, 1'b0, 1'b0, 1'b0, 16'h12f6));
      send_item(make_item(MODE_TABLE_READ, 2'd3, 16'h001e, 1'b0, 1'b0, 1'b0, 1'b1, 16'h0000));
      send_item(make_item(MODE_TABLE_READ, 2'd3, 16'h001f, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000));
   endtask

   // Status writes: forced-zero bits, enable clearing the lock bits, a locked
   // register keeping only its low bits, and a maintenance-mode write that is
   // mapped while the register is locked.
   task automatic test_status_register();
      send_item(make_item(MODE_STATUS_WRITE, 2'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 16'hffff));
      send_item(make_item(MODE_STATUS_WRITE, 2'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 16'he100));
      send_item(make_item(MODE_TRANSLATE, 2'd3, 16'hfff0, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0000));
      send_item(make_item(MODE_STATUS_WRITE, 2'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0cfe));
      send_item(make_item(MODE_STATUS_WRITE, 2'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0001));
   endtask

   // Translation checks on kernel instruction page 1 (table offset 0x02) in
   // 22-bit mode with every data space enabled and 960 KiB installed.
   task automatic test_translation_checks();
      apply_settings(16'h0017, 23'h0f0000);
      // Trap on every access; the write also marks the page as written.
      send_item(make_item(MODE_TABLE_WORD, 2'd0, 16'h0002, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0004));
      send_item(make_item(MODE_TRANSLATE, 2'd0, 16'h2000, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000));
      send_item(make_item(MODE_TRANSLATE, 2'd0, 16'h2000, 1'b1, 1'b0, 1'b1, 1'b0, 16'h0000));
      // Rewriting the base clears the written and accessed bits again.
      send_item(make_item(MODE_TABLE_WORD, 2'd0, 16'h0002, 1'b0, 1'b0, 1'b0, 1'b1, 16'hffff));
      send_item(make_item(MODE_TABLE_READ, 2'd0, 16'h0002, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000));
      send_item(make_item(MODE_STATUS_WRITE, 2'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0001));
      // Expand-down page of full length with the highest base: the sum wraps
      // at 22 bits, and a low block number breaks the length rule.
      send_item(make_item(MODE_TABLE_WORD, 2'd0, 16'h0002, 1'b0, 1'b0, 1'b0, 1'b0, 16'h7f0e));
      send_item(make_item(MODE_TRANSLATE, 2'd0, 16'h2040, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000));
      send_item(make_item(MODE_TRANSLATE, 2'd0, 16'h3fff, 1'b1, 1'b0, 1'b1, 1'b0, 16'h0000));
      send_item(make_item(MODE_STATUS_WRITE, 2'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0001));
      // Above installed memory but below the I/O page aborts.
      send_item(make_item(MODE_TABLE_WORD, 2'd0, 16'h0002, 1'b0, 1'b0, 1'b0, 1'b1, 16'h4000));
      send_item(make_item(MODE_TRANSLATE, 2'd0, 16'h3fff, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000));
      // Inside the I/O page memory size no longer matters.
      send_item(make_item(MODE_TABLE_WORD, 2'd0, 16'h0002, 1'b0, 1'b0, 1'b0, 1'b1, 16'hff80));
      send_item(make_item(MODE_TRANSLATE, 2'd0, 16'h3fff, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000));
      // User data space is enabled; run mode 2 never gets one.
      send_item(make_item(MODE_TRANSLATE, 2'd3, 16'he000, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000));
      send_item(make_item(MODE_TRANSLATE, 2'd2, 16'he000, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0000));
   endtask

   // Random traffic under several settings, the register extremes among them.
   // One setting runs with no idling on either side.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       apply_settings(MMR3_RESET, MEMSIZE_RESET);
            1:       apply_settings(16'hffff, 23'd4194304);
            2:       apply_settings(16'h0010, 23'd0);
            3:       apply_settings(16'h0007, 23'h020000);
            default: apply_settings(16'($urandom), 23'($urandom_range(0, 4194304)));
         endcase
         idle_on = (phase != 3);
         repeat (ITEMS_PER_SETTING) send_item(random_item());
      end
      idle_on = 1'b1;
   endtask

   // The result side stalls at random, changing ready only at falling edges.
   initial begin : stall_ready
      int g;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            g = pick_gap();
            if (g > 0) begin
               stall_left = g - 1;
               rsp_bus.ready <= 1'b0;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   // Every accepted result is matched against the oldest expectation.
   always @(posedge clock) begin : check_results
      mmu_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("result arrived with no item outstanding");
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            results_checked++;
            if (want.fault == FAULT_ABORT) abort_count++;
            if (want.fault == FAULT_TRAP) trap_count++;
            if (rsp_bus.physical_address !== want.paddr) begin
               $error("physical_address: expected %h actual %h",
                      want.paddr, rsp_bus.physical_address);
               error_count++;
            end
            if (rsp_bus.fault !== want.fault) begin
               $error("fault: expected %0d actual %0d", want.fault, rsp_bus.fault);
               error_count++;
            end
            if (rsp_bus.read_data !== want.rdata) begin
               $error("read_data: expected %h actual %h", want.rdata, rsp_bus.read_data);
               error_count++;
            end
            if (rsp_bus.status_value !== want.status) begin
               $error("status_value: expected %h actual %h",
                      want.status, rsp_bus.status_value);
               error_count++;
            end
         end
      end
   end

   initial begin
      // Every input is known from time zero; reset is asserted until the tests start.
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_MMR3;
      csr_wr_data = '0;
      req_bus.valid        = 1'b0;
      req_bus.mode         = MODE_TRANSLATE;
      req_bus.cpu_mode     = '0;
      req_bus.vaddr        = '0;
      req_bus.write_access = 1'b0;
      req_bus.data_space   = 1'b0;
      req_bus.check_access = 1'b0;
      req_bus.table_select = 1'b0;
      req_bus.write_data   = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         pbr_shadow[i] = '0;
         pdr_shadow[i] = '0;
      end
      sr0_shadow     = '0;
      mmr3_shadow    = MMR3_RESET;
      memsize_shadow = MEMSIZE_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_unmapped();
      test_table_access();
      test_status_register();
      test_translation_checks();
      test_random_traffic();

      wait_idle();
      repeat (8) @(posedge clock);

      $display("Sent %0d items under %0d register settings and checked %0d results.",
               items_sent, settings_count, results_checked);
      $display("Predicted faults among them: %0d aborts and %0d traps.",
               abort_count, trap_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // A handshake that never completes ends the run here.
   initial begin
      #(TIMEOUT_UNITS);
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/smmu_pkg.sv
rtl/smmu_ifaces.sv
rtl/smmu_ram.sv
rtl/segmented_mmu_translate_check.sv
tb/sv/segmented_mmu_translate_check_test.sv
